// ===== design/sngc_pkg.sv =====
// Shared constants, types and pair tables for the grid next-cell step.
// No dependencies; every other design file imports this package.
`default_nettype none
package sngc_pkg;

    localparam int NDIM    = 3;       // lanes, one per grid dimension
    localparam int IDX_W   = 10;      // cell index width
    localparam int CRD_W   = 32;      // Q16.16 coordinate
    localparam int W_W     = 31;      // cell width
    localparam int SIDE_W  = IDX_W + 1;
    localparam int DF_W    = CRD_W + 1;
    localparam int KW_W    = W_W + SIDE_W - 1;   // k * width, k up to 1024
    localparam int NUM_W   = KW_W + 2;           // signed crossing numerator
    localparam int MAG_W   = NUM_W - 1;
    localparam int DEN_W   = CRD_W;
    localparam int HALF_W  = MAG_W / 2;
    localparam int PP_W    = HALF_W + DEN_W;
    localparam int PRD_W   = MAG_W + DEN_W;
    localparam int TH_W    = MAG_W + 7;
    localparam int A1_W    = IDX_W + SIDE_W;
    localparam int A2_W    = A1_W + SIDE_W;
    localparam int ADDR_W  = 30;
    localparam int NPAIR   = 3;
    localparam int LAT     = 8;

    localparam int IN_W    = 224;
    localparam int OUT_W   = 64;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 32;

    localparam logic [CFG_IW-1:0] CFG_DIMS   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_ORG_X  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ORG_Y  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_ORG_Z  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_W_X    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_W_Y    = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_W_Z    = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_CELLS  = 3'd7;

    // lanes compared by each pair
    localparam int PAIR_A [NPAIR] = '{0, 0, 1};
    localparam int PAIR_B [NPAIR] = '{1, 2, 2};

    typedef struct packed {
        logic             valid;   // interior face crossed below 1.01
        logic             high;    // moving towards the high face
        logic             same;    // end cell equals current cell
        logic [IDX_W-1:0] cur;
    } lane_info_t;

endpackage
`default_nettype wire

// ===== design/sngc_lane.sv =====
// One dimension's lane: end-cell test, face crossing fraction and 1.01 limit.
// Depends on sngc_pkg. Three register stages.
`default_nettype none
module sngc_lane
    import sngc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic                    act,
    input  wire logic signed [CRD_W-1:0] p1,
    input  wire logic signed [CRD_W-1:0] p2,
    input  wire logic signed [CRD_W-1:0] org,
    input  wire logic [IDX_W-1:0]        cur,
    input  wire logic [W_W-1:0]          w,
    input  wire logic [SIDE_W-1:0]       side,
    output lane_info_t                   info,
    output logic                         sgn,
    output logic [MAG_W-1:0]             mag,
    output logic [DEN_W-1:0]             den
);

    // stage 1
    logic [KW_W-1:0]        cw_reg;
    logic signed [DF_W-1:0] diff_reg, dd_reg, op_reg;
    logic [IDX_W-1:0]       cur1_reg;
    logic                   act1_reg;

    // stage 2
    logic [KW_W-1:0]         cw1;
    logic signed [NUM_W-1:0] diff_x, cw_s, cw1_s, op_x, kw_s, num_s, num_next;
    logic                    low_ok, high_ok, in_grid, hi, face_ok, same_next;
    logic [SIDE_W-1:0]       k;
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]        den2_reg;
    logic                    same2_reg, face2_reg, high2_reg;
    logic [IDX_W-1:0]        cur2_reg;

    // stage 3
    logic [MAG_W-1:0] mag_next;
    logic [TH_W-1:0]  lhs, rhs;
    logic             valid_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            cw_reg   <= KW_W'(cur) * KW_W'(w);
            diff_reg <= {p2[CRD_W-1], p2} - {org[CRD_W-1], org};
            dd_reg   <= {p2[CRD_W-1], p2} - {p1[CRD_W-1], p1};
            op_reg   <= {org[CRD_W-1], org} - {p1[CRD_W-1], p1};
            cur1_reg <= act ? cur : '0;
            act1_reg <= act;
        end
    end

    always_comb begin
        cw1    = cw_reg + KW_W'(w);
        diff_x = {{(NUM_W-DF_W){diff_reg[DF_W-1]}}, diff_reg};
        op_x   = {{(NUM_W-DF_W){op_reg[DF_W-1]}}, op_reg};
        cw_s   = signed'({2'b00, cw_reg});
        cw1_s  = signed'({2'b00, cw1});
        // clamped end cell equals cur
        in_grid = {1'b0, cur1_reg} < side;
        low_ok  = (cur1_reg == '0) || (diff_x >= cw_s);
        high_ok = ({1'b0, cur1_reg} == side - SIDE_W'(1)) || (diff_x < cw1_s);
        same_next = !act1_reg || (in_grid && low_ok && high_ok);
        hi      = !dd_reg[DF_W-1] && (dd_reg != '0);
        k       = {1'b0, cur1_reg} + SIDE_W'(hi);
        face_ok = act1_reg && (dd_reg != '0) && (k != '0) && (k < side);
        kw_s    = hi ? cw1_s : cw_s;
        num_s   = op_x + kw_s;
        num_next = dd_reg[DF_W-1] ? -num_s : num_s;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg   <= num_next;
            den2_reg  <= dd_reg[DF_W-1] ? DEN_W'(-dd_reg) : DEN_W'(dd_reg);
            same2_reg <= same_next;
            face2_reg <= face_ok;
            high2_reg <= hi;
            cur2_reg  <= cur1_reg;
        end
    end

    always_comb begin
        mag_next   = num_reg[NUM_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
        lhs        = TH_W'(mag_next) * TH_W'(100);
        rhs        = TH_W'(den2_reg) * TH_W'(101);
        valid_next = face2_reg && (num_reg[NUM_W-1] || (lhs < rhs));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            info.valid <= valid_next;
            info.high  <= high2_reg;
            info.same  <= same2_reg;
            info.cur   <= cur2_reg;
            sgn        <= num_reg[NUM_W-1];
            mag        <= mag_next;
            den        <= den2_reg;
        end
    end

endmodule
`default_nettype wire

// ===== design/sngc_cmp.sv =====
// Pairwise exact fraction compare by cross multiplication, split in halves.
// Depends on sngc_pkg. Two register stages, order flags out combinationally.
`default_nettype none
module sngc_cmp
    import sngc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire lane_info_t [NDIM-1:0]  info_i,
    input  wire logic [NDIM-1:0]        sgn_i,
    input  wire logic [NDIM-1:0][MAG_W-1:0] mag_i,
    input  wire logic [NDIM-1:0][DEN_W-1:0] den_i,
    output lane_info_t [NDIM-1:0]       info_o,
    output logic [NDIM-1:0][NDIM-1:0]   lt      // lt[a][b]: lane a strictly earlier
);

    logic [2*NPAIR-1:0][PP_W-1:0]  plo_reg, phi_reg;
    logic [2*NPAIR-1:0][PRD_W-1:0] prod_reg;
    lane_info_t [NDIM-1:0]         info4_reg;
    logic [NDIM-1:0]               sgn4_reg, sgn5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < NPAIR; p++) begin
                plo_reg[2*p]   <= PP_W'(mag_i[PAIR_A[p]][HALF_W-1:0]) * PP_W'(den_i[PAIR_B[p]]);
                phi_reg[2*p]   <= PP_W'(mag_i[PAIR_A[p]][MAG_W-1:HALF_W]) * PP_W'(den_i[PAIR_B[p]]);
                plo_reg[2*p+1] <= PP_W'(mag_i[PAIR_B[p]][HALF_W-1:0]) * PP_W'(den_i[PAIR_A[p]]);
                phi_reg[2*p+1] <= PP_W'(mag_i[PAIR_B[p]][MAG_W-1:HALF_W]) * PP_W'(den_i[PAIR_A[p]]);
            end
            info4_reg <= info_i;
            sgn4_reg  <= sgn_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int q = 0; q < 2*NPAIR; q++) begin
                prod_reg[q] <= {phi_reg[q], HALF_W'(0)} + PRD_W'(plo_reg[q]);
            end
            info_o   <= info4_reg;
            sgn5_reg <= sgn4_reg;
        end
    end

    always_comb begin
        lt = '0;
        for (int p = 0; p < NPAIR; p++) begin
            if (sgn5_reg[PAIR_A[p]] != sgn5_reg[PAIR_B[p]]) begin
                lt[PAIR_A[p]][PAIR_B[p]] = sgn5_reg[PAIR_A[p]];
                lt[PAIR_B[p]][PAIR_A[p]] = sgn5_reg[PAIR_B[p]];
            end else if (sgn5_reg[PAIR_A[p]]) begin
                // both negative: bigger magnitude is earlier
                lt[PAIR_A[p]][PAIR_B[p]] = prod_reg[2*p] > prod_reg[2*p+1];
                lt[PAIR_B[p]][PAIR_A[p]] = prod_reg[2*p] < prod_reg[2*p+1];
            end else begin
                lt[PAIR_A[p]][PAIR_B[p]] = prod_reg[2*p] < prod_reg[2*p+1];
                lt[PAIR_B[p]][PAIR_A[p]] = prod_reg[2*p] > prod_reg[2*p+1];
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/sngc_merge.sv =====
// Merge: earliest crossing set, tie rule, next cell and row-major address.
// Depends on sngc_pkg. Three register stages, the last is the output register.
`default_nettype none
module sngc_merge
    import sngc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [1:0]                ndim,
    input  wire logic [SIDE_W-1:0]         side_y,
    input  wire logic [SIDE_W-1:0]         side_z,
    input  wire lane_info_t [NDIM-1:0]     info,
    input  wire logic [NDIM-1:0][NDIM-1:0] lt,
    output logic                           at_end,
    output logic [NDIM-1:0][IDX_W-1:0]     nx,
    output logic [ADDR_W-1:0]              addr
);

    logic [NDIM-1:0]              is_min;
    logic                         have, all_same, all_low, end_next;
    logic [NDIM-1:0][IDX_W-1:0]   nx_next;
    logic [NDIM-1:0][IDX_W-1:0]   nx6_reg, nx7_reg;
    logic                         end6_reg, end7_reg;
    logic [A1_W-1:0]              a1_reg;
    logic [A2_W-1:0]              a2;

    always_comb begin
        have     = 1'b0;
        all_same = 1'b1;
        for (int d = 0; d < NDIM; d++) begin
            is_min[d] = info[d].valid;
            for (int e = 0; e < NDIM; e++) begin
                if (e != d && info[e].valid && lt[e][d]) begin
                    is_min[d] = 1'b0;
                end
            end
            have     = have | info[d].valid;
            all_same = all_same & info[d].same;
        end
        all_low = 1'b1;
        for (int d = 0; d < NDIM; d++) begin
            if (is_min[d] && info[d].high) begin
                all_low = 1'b0;
            end
        end
        for (int d = 0; d < NDIM; d++) begin
            if (is_min[d] && info[d].high) begin
                nx_next[d] = info[d].cur + IDX_W'(1);
            end else if (is_min[d] && all_low) begin
                nx_next[d] = info[d].cur - IDX_W'(1);
            end else begin
                nx_next[d] = info[d].cur;
            end
        end
        end_next = all_same || !have;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx6_reg  <= nx_next;
            end6_reg <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ndim >= 2'd2) begin
                a1_reg <= A1_W'(nx6_reg[0]) * A1_W'(side_y) + A1_W'(nx6_reg[1]);
            end else begin
                a1_reg <= A1_W'(nx6_reg[0]);
            end
            nx7_reg  <= nx6_reg;
            end7_reg <= end6_reg;
        end
    end

    assign a2 = (ndim == 2'd3) ? A2_W'(a1_reg) * A2_W'(side_z) + A2_W'(nx7_reg[2])
                               : A2_W'(a1_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            at_end <= end7_reg;
            nx     <= end7_reg ? '0 : nx7_reg;
            addr   <= end7_reg ? '0 : a2[ADDR_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== design/segment_next_grid_cell.sv =====
// Grid next-cell step: next cell entered by a segment, or an end flag.
// Requests pass lane, compare and merge registers; one request per cycle unless held.
// The whole pipeline, three lanes plus pair compare and merge, holds while
// the output register waits on m_tready. Synchronous active-low reset clears
// the pipeline valids and loads the configuration defaults.
// Depends on sngc_pkg, sngc_lane, sngc_cmp, sngc_merge.
`default_nettype none
module segment_next_grid_cell
    import sngc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, cur_x, cur_y, cur_z, pad
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // next_x, next_y, next_z, next_address, pad
    output logic [OUT_W-1:0]       m_tdata,
    output logic                   m_tlast   // at_end
);

    logic [1:0]                    dims_reg;
    logic [NDIM-1:0][CRD_W-1:0]    org_reg;
    logic [NDIM-1:0][W_W-1:0]      cw_reg;
    logic [NDIM*IDX_W-1:0]         cells_reg;
    logic [LAT-1:0]                vld_reg;
    logic                          en;
    logic [1:0]                    ndim;
    logic [NDIM-1:0]               act;
    logic [NDIM-1:0][W_W-1:0]      w_eff;
    logic [NDIM-1:0][SIDE_W-1:0]   side;

    lane_info_t [NDIM-1:0]         l_info, c_info;
    logic [NDIM-1:0]               l_sgn;
    logic [NDIM-1:0][MAG_W-1:0]    l_mag;
    logic [NDIM-1:0][DEN_W-1:0]    l_den;
    logic [NDIM-1:0][NDIM-1:0]     lt;
    logic                          at_end;
    logic [NDIM-1:0][IDX_W-1:0]    nx;
    logic [ADDR_W-1:0]             addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg  <= 2'd3;
            org_reg   <= '0;
            cw_reg    <= {NDIM{W_W'(65536)}};
            cells_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DIMS:  dims_reg   <= cfg_wdata[1:0];
                CFG_ORG_X: org_reg[0] <= cfg_wdata;
                CFG_ORG_Y: org_reg[1] <= cfg_wdata;
                CFG_ORG_Z: org_reg[2] <= cfg_wdata;
                CFG_W_X:   cw_reg[0]  <= cfg_wdata[W_W-1:0];
                CFG_W_Y:   cw_reg[1]  <= cfg_wdata[W_W-1:0];
                CFG_W_Z:   cw_reg[2]  <= cfg_wdata[W_W-1:0];
                CFG_CELLS: cells_reg  <= cfg_wdata[NDIM*IDX_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        ndim = (dims_reg == 2'd0) ? 2'd1 : dims_reg;
        for (int d = 0; d < NDIM; d++) begin
            act[d]   = 2'(d) < ndim;
            w_eff[d] = (cw_reg[d] == '0) ? W_W'(1) : cw_reg[d];
            side[d]  = {1'b0, cells_reg[d*IDX_W +: IDX_W]} + SIDE_W'(1);
        end
    end

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    for (genvar d = 0; d < NDIM; d++) begin : g_lane
        sngc_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .act  (act[d]),
            .p1   (s_tdata[d*CRD_W +: CRD_W]),
            .p2   (s_tdata[(NDIM+d)*CRD_W +: CRD_W]),
            .org  (org_reg[d]),
            .cur  (s_tdata[2*NDIM*CRD_W + d*IDX_W +: IDX_W]),
            .w    (w_eff[d]),
            .side (side[d]),
            .info (l_info[d]),
            .sgn  (l_sgn[d]),
            .mag  (l_mag[d]),
            .den  (l_den[d])
        );
    end

    sngc_cmp u_cmp (
        .aclk   (aclk),
        .en     (en),
        .info_i (l_info),
        .sgn_i  (l_sgn),
        .mag_i  (l_mag),
        .den_i  (l_den),
        .info_o (c_info),
        .lt     (lt)
    );

    sngc_merge u_merge (
        .aclk   (aclk),
        .en     (en),
        .ndim   (ndim),
        .side_y (side[1]),
        .side_z (side[2]),
        .info   (c_info),
        .lt     (lt),
        .at_end (at_end),
        .nx     (nx),
        .addr   (addr)
    );

    assign m_tdata = {(OUT_W - ADDR_W - NDIM*IDX_W)'(0), addr, nx[2], nx[1], nx[0]};
    assign m_tlast = at_end;

endmodule
`default_nettype wire

// ===== design/sngc_chk.sv =====
// Port-level checker for the grid next-cell step, bound to the top level.
// Depends on sngc_pkg and segment_next_grid_cell.
`default_nettype none
module sngc_chk
    import sngc_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == '0)
        else $error("end result carries a cell");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while pipeline held");

endmodule

bind segment_next_grid_cell sngc_chk u_sngc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/segment_next_grid_cell_test.sv =====
// Self-checking bench for the grid next-cell step: random and directed
// segment requests, predicted in-bench and compared field by field.
// Depends on sngc_pkg and segment_next_grid_cell.
`timescale 1ns / 100ps
module segment_next_grid_cell_test;
    import sngc_pkg::*;

    typedef struct packed {
        logic [9:0]  cz, cy, cx;
        logic [31:0] ez, ey, ex, sz, sy, sx;
    } req_t;

    typedef struct {
        logic       last;
        logic [9:0] nx, ny, nz;
        logic [29:0] addr;
    } step_t;

    logic aclk = 0, aresetn = 0;
    logic cfg_we = 0;
    logic [CFG_IW-1:0] cfg_index = CFG_DIMS;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, m_tlast;
    logic [IN_W-1:0] s_tdata = '0;
    logic [OUT_W-1:0] m_tdata;

    segment_next_grid_cell u_top (.*);

    always #5 aclk = ~aclk;

    // mirrored configuration
    logic [1:0]  g_dims;
    logic [31:0] g_org [3];
    logic [30:0] g_w [3];
    logic [29:0] g_cells;

    req_t  pending [$];
    step_t next_cells [$];
    int    errors = 0;
    int    s_gap = 0, m_gap = 0;
    bit    feeding = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // exact comparison of n1/d1 with n2/d2, positive denominators
    function automatic int frac_cmp(longint n1, longint d1, longint n2, longint d2);
        logic signed [127:0] a, b;
        a = 128'(signed'(n1)) * 128'(signed'(d2));
        b = 128'(signed'(n2)) * 128'(signed'(d1));
        return (a < b) ? -1 : (a > b) ? 1 : 0;
    endfunction

    function automatic step_t next_cell(req_t q);
        step_t  r;
        int     n;
        longint p1[3], p2[3], o[3], w[3], side[3], cur[3], nx[3], num[3], den[3];
        bit     ok[3], hi[3], have, all_low, same;
        longint bn, bd, diff, ecell, k;
        logic [63:0] addr;
        n = (g_dims == 0) ? 1 : g_dims;
        have = 0; all_low = 1; same = 1; bn = 0; bd = 1; addr = 0;
        p1 = '{longint'(signed'(q.sx)), longint'(signed'(q.sy)), longint'(signed'(q.sz))};
        p2 = '{longint'(signed'(q.ex)), longint'(signed'(q.ey)), longint'(signed'(q.ez))};
        cur = '{longint'(q.cx), longint'(q.cy), longint'(q.cz)};
        for (int d = 0; d < 3; d++) begin
            nx[d] = 0; ok[d] = 0; hi[d] = 0; num[d] = 0; den[d] = 1;
            o[d] = longint'(signed'(g_org[d]));
            w[d] = (g_w[d] == 0) ? 1 : longint'(g_w[d]);
            side[d] = longint'(g_cells[10*d +: 10]) + 1;
        end
        for (int d = 0; d < n; d++) begin
            diff = p2[d] - o[d];
            ecell = diff < 0 ? 0 : diff / w[d];
            if (ecell > side[d] - 1) ecell = side[d] - 1;
            if (ecell != cur[d]) same = 0;
            nx[d] = cur[d];
        end
        if (!same)
            for (int d = 0; d < n; d++) begin
                if (p2[d] == p1[d]) continue;
                hi[d] = p2[d] > p1[d];
                k = cur[d] + hi[d];
                if (k <= 0 || k >= side[d]) continue;
                num[d] = o[d] + k * w[d] - p1[d];
                den[d] = p2[d] - p1[d];
                if (den[d] < 0) begin
                    den[d] = -den[d];
                    num[d] = -num[d];
                end
                if (frac_cmp(num[d], den[d], 101, 100) >= 0) continue;
                ok[d] = 1;
                if (!have || frac_cmp(num[d], den[d], bn, bd) < 0) begin
                    bn = num[d]; bd = den[d]; have = 1;
                end
            end
        r = '{1'b1, 10'd0, 10'd0, 10'd0, 30'd0};
        if (same || !have) return r;
        for (int d = 0; d < n; d++)
            if (ok[d] && frac_cmp(num[d], den[d], bn, bd) == 0 && hi[d]) all_low = 0;
        for (int d = 0; d < n; d++) begin
            if (!ok[d] || frac_cmp(num[d], den[d], bn, bd) != 0) continue;
            if (hi[d]) nx[d] = cur[d] + 1;
            else if (all_low) nx[d] = cur[d] - 1;
        end
        for (int d = 0; d < n; d++)
            addr = addr * 64'(side[d]) + 64'(nx[d] & 1023);
        r.last = 0;
        r.nx = nx[0][9:0]; r.ny = nx[1][9:0]; r.nz = nx[2][9:0];
        r.addr = addr[29:0];
        return r;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                next_cells.push_back(next_cell(req_t'(s_tdata[$bits(req_t)-1:0])));
                s_gap <= gap_len();
            end
            if (s_tvalid && !s_tready) begin
            end else if (feeding && pending.size() > 0 && (s_gap == 0 || s_tvalid)) begin
                if (s_tvalid && s_tready && s_gap == 0 && gap_len() == 0) begin
                    s_tdata  <= IN_W'(pending.pop_front());
                    s_tvalid <= 1;
                end else if (!(s_tvalid && s_tready) && s_gap == 0) begin
                    s_tdata  <= IN_W'(pending.pop_front());
                    s_tvalid <= 1;
                end else begin
                    s_tvalid <= 0;
                end
            end else begin
                s_tvalid <= 0;
                if (s_gap > 0 && !(s_tvalid && s_tready)) s_gap <= s_gap - 1;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        step_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (next_cells.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    e = next_cells.pop_front();
                    if (m_tlast !== e.last || m_tdata[9:0] !== e.nx
                            || m_tdata[19:10] !== e.ny || m_tdata[29:20] !== e.nz
                            || m_tdata[59:30] !== e.addr) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp last %b %0d %0d %0d a %0d, got %b %0d %0d %0d a %0d",
                                e.last, e.nx, e.ny, e.nz, e.addr, m_tlast, m_tdata[9:0],
                                m_tdata[19:10], m_tdata[29:20], m_tdata[59:30]);
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if ($urandom_range(0, 3) == 0) m_gap <= gap_len();
            end
        end
    end

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] v);
        @(posedge aclk);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            CFG_DIMS:  g_dims = v[1:0];
            CFG_ORG_X: g_org[0] = v;
            CFG_ORG_Y: g_org[1] = v;
            CFG_ORG_Z: g_org[2] = v;
            CFG_W_X:   g_w[0] = v[30:0];
            CFG_W_Y:   g_w[1] = v[30:0];
            CFG_W_Z:   g_w[2] = v[30:0];
            default:   g_cells = v[29:0];
        endcase
    endtask

    // coordinate inside or near the configured grid, sometimes anywhere
    function automatic logic [31:0] coord(int d);
        longint span;
        if ($urandom_range(0, 9) == 0) return $urandom;
        span = (longint'(g_cells[10*d +: 10]) + 1) * longint'(g_w[d]);
        return 32'(longint'(signed'(g_org[d])) - g_w[d] +
                   longint'($urandom_range(0, 32'(span + 2 * g_w[d]))));
    endfunction

    function automatic logic [31:0] cell_of(int d, logic [31:0] p);
        longint c;
        c = (longint'(signed'(p)) - longint'(signed'(g_org[d])));
        c = c < 0 ? 0 : c / ((g_w[d] == 0) ? 1 : g_w[d]);
        if (c > g_cells[10*d +: 10]) c = g_cells[10*d +: 10];
        return 32'(c);
    endfunction

    function automatic req_t rand_req();
        req_t q;
        q.sx = coord(0); q.sy = coord(1); q.sz = coord(2);
        q.ex = coord(0); q.ey = coord(1); q.ez = coord(2);
        // mostly the start cell, sometimes a neighbour or noise
        q.cx = 10'(cell_of(0, q.sx)); q.cy = 10'(cell_of(1, q.sy));
        q.cz = 10'(cell_of(2, q.sz));
        if ($urandom_range(0, 7) == 0) q.cx = 10'($urandom);
        if ($urandom_range(0, 7) == 0) q.cy = q.cy + 10'd1;
        if ($urandom_range(0, 7) == 0) q.ez = q.sz;
        return q;
    endfunction

    task automatic run_phase();
        feeding = 1;
        wait (pending.size() == 0 && !s_tvalid);
        wait (next_cells.size() == 0);
        feeding = 0;
        repeat (LAT + 4) @(posedge aclk);
    endtask

    initial begin
        req_t q;
        g_dims = 3; g_org = '{0, 0, 0}; g_w = '{31'd65536, 31'd65536, 31'd65536};
        g_cells = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        // reset grid: single cell, always at end
        pending.push_back('0);
        pending.push_back('1);
        run_phase();
        write_reg(CFG_CELLS, {10'd3, 10'd3, 10'd3});
        // directed: diagonal tie, low-side moves, extremes
        pending.push_back('{10'd0, 10'd0, 10'd0, 32'h30000, 32'h30000, 32'h30000,
                           32'h8000, 32'h8000, 32'h8000});
        pending.push_back('{10'd1, 10'd1, 10'd1, 32'h8000, 32'h8000, 32'h8000,
                           32'h18000, 32'h18000, 32'h18000});
        pending.push_back('{10'd1, 10'd1, 10'd1, 32'h28000, 32'h8000, 32'h18000,
                           32'h18000, 32'h18000, 32'h18000});
        pending.push_back('{10'd0, 10'd0, 10'd0, 32'h0, 32'h0, 32'h1028F,
                           32'h0, 32'h0, 32'h8000});
        pending.push_back('{10'd0, 10'd0, 10'd0, 32'h0, 32'h0, 32'h10290,
                           32'h0, 32'h0, 32'h0});
        pending.push_back('{10'h3FF, 10'h3FF, 10'h3FF, 32'h7FFFFFFF, 32'h80000000,
                           32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000});
        pending.push_back('{10'd3, 10'd0, 10'd2, 32'h80000000, 32'h7FFFFFFF,
                           32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0});
        run_phase();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_DIMS, 1); write_reg(CFG_CELLS, 30'h3FF); end
                1: begin
                    write_reg(CFG_DIMS, 2); write_reg(CFG_ORG_X, 32'hFFF80000);
                    write_reg(CFG_ORG_Y, 32'h00012345); write_reg(CFG_W_Y, 32'h8000);
                    write_reg(CFG_CELLS, {10'd0, 10'd15, 10'd7});
                end
                2: begin
                    write_reg(CFG_DIMS, 3); write_reg(CFG_W_X, 1); write_reg(CFG_W_Y, 3);
                    write_reg(CFG_W_Z, 7); write_reg(CFG_ORG_Z, 32'h80000000);
                    write_reg(CFG_CELLS, {10'd5, 10'd5, 10'd5});
                end
                3: begin
                    write_reg(CFG_W_X, 32'h7FFFFFFF); write_reg(CFG_W_Y, 0);
                    write_reg(CFG_W_Z, 32'h00010000); write_reg(CFG_CELLS, 30'h3FFFFFFF);
                    write_reg(CFG_ORG_X, 32'h80000000); write_reg(CFG_ORG_Y, 0);
                end
                4: begin
                    write_reg(CFG_DIMS, 0); write_reg(CFG_W_X, 32'h4000);
                    write_reg(CFG_ORG_X, 32'h7FFF0000); write_reg(CFG_CELLS, 30'd9);
                end
                default: begin
                    write_reg(CFG_DIMS, 3); write_reg(CFG_ORG_X, 0);
                    write_reg(CFG_ORG_Y, 32'hFFFF0000); write_reg(CFG_ORG_Z, 32'h20000);
                    write_reg(CFG_W_X, 32'h10000); write_reg(CFG_W_Y, 32'h18000);
                    write_reg(CFG_W_Z, 32'h6000); write_reg(CFG_CELLS, {10'd4, 10'd9, 10'd7});
                end
            endcase
            for (int i = 0; i < 100; i++) pending.push_back(rand_req());
            run_phase();
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
